/* rtl/edh_pkg.sv */
// ----------------------------------------------------------------------------
// edh_pkg
// shared constants, request and status codes, sequencer states
// ----------------------------------------------------------------------------
package edh_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_MAX_EDGES    = 16384;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_EDGE_READ = 3'd4;
    localparam logic [2:0] ST_NO_MORE   = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_INS_BKT,
        S_INS_CHK,
        S_INS_ALLOC,
        S_INS_LINK,
        S_RD_LINK,
        S_RD_SCAN,
        S_RD_OUT,
        S_RESP
    } seq_state_t;

endpackage

/* rtl/edh_key.sv */
// ----------------------------------------------------------------------------
// edh_key
// vertex limit register, id check and bucket hash
// ----------------------------------------------------------------------------
module edh_key
    import edh_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = VW + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [NW-1:0] cfg_wr_data,
    input  logic [VW-1:0] first_vertex,
    input  logic [VW-1:0] second_vertex,
    output logic          ids_ok,
    output logic [VW-1:0] bucket
);

    localparam logic [NW-1:0] MAXV = NW'(MAX_VERTICES);

    logic [NW-1:0] num_vertices_reg;
    logic [NW-1:0] lim;
    logic [NW-1:0] sum;
    logic [NW-1:0] red;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vertices_reg <= MAXV;
        end else if (cfg_wr_en) begin
            num_vertices_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        lim    = (num_vertices_reg > MAXV) ? MAXV : num_vertices_reg;
        ids_ok = ({1'b0, first_vertex} < lim) && ({1'b0, second_vertex} < lim);
        sum    = {1'b0, first_vertex} + {1'b0, second_vertex};
        red    = (sum >= lim) ? (sum - lim) : sum;
        bucket = red[VW-1:0];
    end

endmodule

/* rtl/edh_out_reg.sv */
// ----------------------------------------------------------------------------
// edh_out_reg
// result beat register between sequencer and result channel
// ----------------------------------------------------------------------------
module edh_out_reg
    import edh_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int EW = $clog2(MAX_EDGES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    output logic          free,
    input  logic [2:0]    res_status,
    input  logic [VW-1:0] res_first,
    input  logic [VW-1:0] res_second,
    input  logic          res_last,
    input  logic [EW-1:0] res_count,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [VW-1:0] m_out_first,
    output logic [VW-1:0] m_out_second,
    output logic          m_is_last,
    output logic [EW-1:0] m_stored_count
);

    logic          valid_reg;
    logic [2:0]    status_reg;
    logic [VW-1:0] first_reg;
    logic [VW-1:0] second_reg;
    logic          last_reg;
    logic [EW-1:0] count_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            status_reg <= res_status;
            first_reg  <= res_first;
            second_reg <= res_second;
            last_reg   <= res_last;
            count_reg  <= res_count;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_out_first    = first_reg;
    assign m_out_second   = second_reg;
    assign m_is_last      = last_reg;
    assign m_stored_count = count_reg;

endmodule

/* rtl/edh_core.sv */
// ----------------------------------------------------------------------------
// edh_core
// request sequencer with bucket head memory and entry memory
// ----------------------------------------------------------------------------
module edh_core
    import edh_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = VW + 1,
    localparam int EW = $clog2(MAX_EDGES + 1),
    localparam int IW = $clog2(MAX_EDGES),
    localparam int DW = 2 * VW + EW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_req_type,
    input  logic [VW-1:0] s_first_vertex,
    input  logic [VW-1:0] s_second_vertex,
    input  logic          ids_ok,
    input  logic [VW-1:0] bucket,
    output logic          out_push,
    input  logic          out_free,
    output logic [2:0]    res_status,
    output logic [VW-1:0] res_first,
    output logic [VW-1:0] res_second,
    output logic          res_last,
    output logic [EW-1:0] res_count
);

    localparam logic [EW-1:0] NULL_PTR  = EW'(MAX_EDGES);
    localparam logic [VW-1:0] LAST_BKT  = VW'(MAX_VERTICES - 1);

    // memories
    logic [EW-1:0] bkt_mem [MAX_VERTICES];
    logic [DW-1:0] ent_mem [MAX_EDGES];

    logic          bkt_we, bkt_re;
    logic [VW-1:0] bkt_wa, bkt_ra;
    logic [EW-1:0] bkt_wd, bkt_rd_reg;
    logic          ent_we, ent_re;
    logic [IW-1:0] ent_wa, ent_ra;
    logic [DW-1:0] ent_wd, ent_rd_reg;

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        if (bkt_re) begin
            bkt_rd_reg <= bkt_mem[bkt_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            ent_rd_reg <= ent_mem[ent_ra];
        end
    end

    logic [VW-1:0] ent_first, ent_second;
    logic [EW-1:0] ent_link;
    assign {ent_first, ent_second, ent_link} = ent_rd_reg;

    seq_state_t    state_reg, state_next;
    logic [VW-1:0] a_reg, a_next, b_reg, b_next;
    logic [VW-1:0] key_reg, key_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic          empty_reg, empty_next;
    logic [EW-1:0] total_reg, total_next;
    logic [VW-1:0] max_bkt_reg, max_bkt_next;
    logic          max_vld_reg, max_vld_next;
    logic [VW-1:0] rd_bkt_reg, rd_bkt_next;
    logic [EW-1:0] rd_ent_reg, rd_ent_next;
    logic [VW-1:0] out_bkt_reg, out_bkt_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [VW-1:0] sweep_reg, sweep_next;
    logic          sweep_req_reg, sweep_req_next;
    logic [2:0]    pst_reg, pst_next;
    logic [VW-1:0] pf_reg, pf_next, ps_reg, ps_next;
    logic          pl_reg, pl_next;
    logic          scan_go;
    logic [NW-1:0] scan_from;
    logic          hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            total_reg     <= '0;
            max_vld_reg   <= 1'b0;
            rd_bkt_reg    <= '0;
            rd_ent_reg    <= NULL_PTR;
            sweep_reg     <= '0;
            sweep_req_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            max_vld_reg   <= max_vld_next;
            rd_bkt_reg    <= rd_bkt_next;
            rd_ent_reg    <= rd_ent_next;
            sweep_reg     <= sweep_next;
            sweep_req_reg <= sweep_req_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        key_reg     <= key_next;
        cur_reg     <= cur_next;
        empty_reg   <= empty_next;
        max_bkt_reg <= max_bkt_next;
        out_bkt_reg <= out_bkt_next;
        scan_reg    <= scan_next;
        pst_reg     <= pst_next;
        pf_reg      <= pf_next;
        ps_reg      <= ps_next;
        pl_reg      <= pl_next;
    end

    assign hit = ((ent_first == a_reg) && (ent_second == b_reg)) ||
                 ((ent_first == b_reg) && (ent_second == a_reg));

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        empty_next     = empty_reg;
        total_next     = total_reg;
        max_bkt_next   = max_bkt_reg;
        max_vld_next   = max_vld_reg;
        rd_bkt_next    = rd_bkt_reg;
        rd_ent_next    = rd_ent_reg;
        out_bkt_next   = out_bkt_reg;
        scan_next      = scan_reg;
        sweep_next     = sweep_reg;
        sweep_req_next = sweep_req_reg;
        pst_next       = pst_reg;
        pf_next        = pf_reg;
        ps_next        = ps_reg;
        pl_next        = pl_reg;
        s_ready        = 1'b0;
        out_push       = 1'b0;
        bkt_we = 1'b0; bkt_wa = key_reg; bkt_wd = total_reg;
        bkt_re = 1'b0; bkt_ra = key_reg;
        ent_we = 1'b0; ent_wa = cur_reg[IW-1:0]; ent_wd = ent_rd_reg;
        ent_re = 1'b0; ent_ra = cur_reg[IW-1:0];
        scan_go   = 1'b0;
        scan_from = scan_reg;

        unique case (state_reg)
            S_SWEEP: begin
                bkt_we     = 1'b1;
                bkt_wa     = sweep_reg;
                bkt_wd     = NULL_PTR;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BKT) begin
                    sweep_next = '0;
                    if (sweep_req_reg) begin
                        pst_next   = ST_CLEARED;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    a_next   = s_first_vertex;
                    b_next   = s_second_vertex;
                    key_next = bucket;
                    pf_next  = '0;
                    ps_next  = '0;
                    pl_next  = 1'b0;
                    unique case (s_req_type)
                        REQ_INSERT: begin
                            if (!ids_ok) begin
                                pst_next   = ST_INVALID;
                                state_next = S_RESP;
                            end else begin
                                bkt_re     = 1'b1;
                                bkt_ra     = bucket;
                                state_next = S_INS_BKT;
                            end
                        end
                        REQ_READ: begin
                            if (rd_ent_reg != NULL_PTR) begin
                                ent_re     = 1'b1;
                                ent_ra     = rd_ent_reg[IW-1:0];
                                state_next = S_RD_LINK;
                            end else begin
                                scan_go   = 1'b1;
                                scan_from = {1'b0, rd_bkt_reg};
                            end
                        end
                        REQ_CLEAR: begin
                            total_next     = '0;
                            rd_bkt_next    = '0;
                            rd_ent_next    = NULL_PTR;
                            max_vld_next   = 1'b0;
                            sweep_next     = '0;
                            sweep_req_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_BKT: begin
                if (bkt_rd_reg == NULL_PTR) begin
                    empty_next = 1'b1;
                    state_next = S_INS_ALLOC;
                end else begin
                    empty_next = 1'b0;
                    cur_next   = bkt_rd_reg;
                    ent_re     = 1'b1;
                    ent_ra     = bkt_rd_reg[IW-1:0];
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (hit) begin
                    pst_next   = ST_DUPLICATE;
                    state_next = S_RESP;
                end else if (ent_link == NULL_PTR) begin
                    state_next = S_INS_ALLOC;
                end else begin
                    cur_next = ent_link;
                    ent_re   = 1'b1;
                    ent_ra   = ent_link[IW-1:0];
                end
            end
            S_INS_ALLOC: begin
                if (total_reg == NULL_PTR) begin
                    pst_next   = ST_FULL;
                    state_next = S_RESP;
                end else begin
                    // hook the new entry onto the bucket head or the chain tail
                    if (empty_reg) begin
                        bkt_we = 1'b1;
                        bkt_wa = key_reg;
                        bkt_wd = total_reg;
                    end else begin
                        ent_we = 1'b1;
                        ent_wa = cur_reg[IW-1:0];
                        ent_wd = {ent_first, ent_second, total_reg};
                    end
                    state_next = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                ent_we     = 1'b1;
                ent_wa     = total_reg[IW-1:0];
                ent_wd     = {a_reg, b_reg, NULL_PTR};
                total_next = total_reg + 1'b1;
                if (!max_vld_reg || (key_reg > max_bkt_reg)) begin
                    max_bkt_next = key_reg;
                end
                max_vld_next = 1'b1;
                pst_next     = ST_INSERTED;
                state_next   = S_RESP;
            end
            S_RD_LINK: begin
                if (ent_link != NULL_PTR) begin
                    cur_next     = ent_link;
                    out_bkt_next = rd_bkt_reg;
                    ent_re       = 1'b1;
                    ent_ra       = ent_link[IW-1:0];
                    state_next   = S_RD_OUT;
                end else begin
                    scan_go   = 1'b1;
                    scan_from = {1'b0, rd_bkt_reg} + 1'b1;
                end
            end
            S_RD_SCAN: begin
                if (bkt_rd_reg != NULL_PTR) begin
                    cur_next     = bkt_rd_reg;
                    out_bkt_next = scan_reg[VW-1:0];
                    ent_re       = 1'b1;
                    ent_ra       = bkt_rd_reg[IW-1:0];
                    state_next   = S_RD_OUT;
                end else begin
                    scan_go   = 1'b1;
                    scan_from = scan_reg + 1'b1;
                end
            end
            S_RD_OUT: begin
                pst_next    = ST_EDGE_READ;
                pf_next     = ent_first;
                ps_next     = ent_second;
                pl_next     = (ent_link == NULL_PTR) && (out_bkt_reg >= max_bkt_reg);
                rd_bkt_next = out_bkt_reg;
                rd_ent_next = cur_reg;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // bucket scan step, ends early past the highest bucket in use
        if (scan_go) begin
            if (!max_vld_reg || (scan_from > {1'b0, max_bkt_reg})) begin
                pst_next    = ST_NO_MORE;
                rd_bkt_next = '0;
                rd_ent_next = NULL_PTR;
                state_next  = S_RESP;
            end else begin
                bkt_re     = 1'b1;
                bkt_ra     = scan_from[VW-1:0];
                scan_next  = scan_from;
                state_next = S_RD_SCAN;
            end
        end
    end

    assign res_status = pst_reg;
    assign res_first  = pf_reg;
    assign res_second = ps_reg;
    assign res_last   = pl_reg;
    assign res_count  = total_reg;

endmodule

/* rtl/edge_dedup_hash_table.sv */
// ----------------------------------------------------------------------------
// edge_dedup_hash_table
// duplicate-free store of undirected edges, chained hash on (v0+v1) mod n
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                                   beat
//   s_*       in         req_type, first_vertex, second_vertex  one request
//   m_*       out        status, out_first, out_second,          one result
//                        is_last, stored_count
//   cfg_*     in         wr_en, wr_data                          vertex limit
//
// insert: reads the bucket head, walks the chain entry by entry, then appends
// read: follows the link of the last edge read, else scans the bucket heads
// for the next one in use; past the highest bucket in use the pass is over
// clear: one bucket head memory write per cycle over every bucket head
// reset: the same head memory clearing pass, no beat taken
// one request at a time through the sequencer; a finished result waits in
// the output register while the next request is taken
//
module edge_dedup_hash_table
    import edh_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = VW + 1,
    localparam int EW = $clog2(MAX_EDGES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    // vertex limit register
    input  logic          cfg_wr_en,
    input  logic [NW-1:0] cfg_wr_data,
    // request channel
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_req_type,
    input  logic [VW-1:0] s_first_vertex,
    input  logic [VW-1:0] s_second_vertex,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [VW-1:0] m_out_first,
    output logic [VW-1:0] m_out_second,
    output logic          m_is_last,
    output logic [EW-1:0] m_stored_count
);

    logic          ids_ok;
    logic [VW-1:0] bucket;
    logic          out_push;
    logic          free;
    logic [2:0]    res_status;
    logic [VW-1:0] res_first;
    logic [VW-1:0] res_second;
    logic          res_last;
    logic [EW-1:0] res_count;

    // id check and bucket hash straight off the request ports
    edh_key #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_key (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .first_vertex  (s_first_vertex),
        .second_vertex (s_second_vertex),
        .ids_ok        (ids_ok),
        .bucket        (bucket)
    );

    // sequencer owning the head and entry memories
    edh_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_first_vertex  (s_first_vertex),
        .s_second_vertex (s_second_vertex),
        .ids_ok          (ids_ok),
        .bucket          (bucket),
        .out_push        (out_push),
        .out_free        (free),
        .res_status      (res_status),
        .res_first       (res_first),
        .res_second      (res_second),
        .res_last        (res_last),
        .res_count       (res_count)
    );

    // result beat register
    edh_out_reg #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (out_push),
        .free           (free),
        .res_status     (res_status),
        .res_first      (res_first),
        .res_second     (res_second),
        .res_last       (res_last),
        .res_count      (res_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_first    (m_out_first),
        .m_out_second   (m_out_second),
        .m_is_last      (m_is_last),
        .m_stored_count (m_stored_count)
    );

endmodule
